// ===== design/spe_pkg.sv =====
// Package: widths, word types and constant lookup tables for the position encoder.
package spe_pkg;

    localparam int MODEL_WIDTH      = 512;
    localparam int MAX_POSITION     = 4096;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int PAIRS = (MODEL_WIDTH + 1) / 2;

    localparam int POS_W   = 12;
    localparam int DIM_W   = 9;
    localparam int VAL_W   = 16;
    localparam int K_W     = DIM_W - 1;
    localparam int K_N     = 1 << K_W;
    localparam int FREQ_W  = 32;
    localparam int PHASE_W = 32;
    localparam int SINE_W  = 12;
    localparam int J_W     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int SUM_W   = VAL_W + 1;

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] LN10000_Q30 = 64'd9889527671;
    localparam logic [63:0] LN2_Q30     = 64'd744261118;
    localparam logic [63:0] INV2PI_Q32  = 64'd683565276;
    localparam logic [63:0] HALFPI_Q30  = 64'd1686629713;

    typedef logic [K_N-1:0][FREQ_W-1:0]            freq_tab_t;
    typedef logic [SINE_TABLE_DEPTH:0][SINE_W-1:0] sine_tab_t;

    // word after frequency lookup
    typedef struct packed {
        logic                    in_range;
        logic                    odd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] emb;
    } freq_word_t;

    // word after phase multiply
    typedef struct packed {
        logic                    in_range;
        logic                    odd;
        logic [PHASE_W-1:0]      phase;
        logic signed [VAL_W-1:0] emb;
    } phase_word_t;

    // word carrying the quarter-wave table index
    typedef struct packed {
        logic                    in_range;
        logic                    neg;
        logic [J_W-1:0]          idx;
        logic signed [VAL_W-1:0] emb;
    } idx_word_t;

    // word carrying the sine magnitude
    typedef struct packed {
        logic                    in_range;
        logic                    neg;
        logic [SINE_W-1:0]       mag;
        logic signed [VAL_W-1:0] emb;
    } mag_word_t;

    // turns per position, Q0.32: exp(-2k ln(10000)/d) / (2 pi)
    function automatic logic [FREQ_W-1:0] make_freq(input int k);
        logic [63:0] x;
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] term;
        logic [63:0] prod;
        longint      sum;
        int          shift;
        x = (64'd2 * 64'(k) * LN10000_Q30 + 64'(MODEL_WIDTH / 2)) / 64'(MODEL_WIDTH);
        n = x / LN2_Q30;
        r = x - n * LN2_Q30;
        term = Q30_ONE;
        sum = longint'(Q30_ONE);
        for (int i = 1; i <= 12; i++) begin
            term = ((term * r) >> 30) / 64'(i);
            if ((i % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (n > 64'd30) begin
            n = 64'd30;
        end
        shift = 30 + int'(n);
        prod = 64'(sum) * INV2PI_Q32;
        prod = (prod + (64'd1 << (shift - 1))) >> shift;
        if (prod > 64'hFFFF_FFFF) begin
            prod = 64'hFFFF_FFFF;
        end
        return prod[FREQ_W-1:0];
    endfunction

    // round(2048 * sin(pi/2 * j / depth))
    function automatic logic [SINE_W-1:0] make_sine(input int j);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] v;
        longint      sum;
        a = HALFPI_Q30 * 64'(j) / 64'(SINE_TABLE_DEPTH);
        a2 = (a * a) >> 30;
        term = a;
        sum = longint'(a);
        for (int i = 1; i <= 8; i++) begin
            term = ((term * a2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if ((i % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        v = (64'(sum) * 64'd2048 + (64'd1 << 29)) >> 30;
        if (v > 64'd2048) begin
            v = 64'd2048;
        end
        return v[SINE_W-1:0];
    endfunction

    function automatic freq_tab_t build_freq_tab();
        freq_tab_t t;
        for (int k = 0; k < K_N; k++) begin
            t[k] = make_freq((k < PAIRS) ? k : PAIRS - 1);
        end
        return t;
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t t;
        for (int j = 0; j <= SINE_TABLE_DEPTH; j++) begin
            t[j] = make_sine(j);
        end
        return t;
    endfunction

    localparam freq_tab_t FREQ_TAB = build_freq_tab();
    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

// ===== design/sinusoidal_position_encoder_top.sv =====
// Top level: sinusoidal positional encoder, five-stage pipeline with saturating add.
//
//   channel | direction | ports
//   --------+-----------+-------------------------------------------------------
//   input   | in        | s_valid/s_ready, s_position, s_dimension, s_embedding_value
//   result  | out       | m_valid/m_ready, m_encoded_value, m_saturated
//
// One word per cycle sustained while m_ready keeps up. Five register stages (freq table read, phase
// multiply, quadrant/index, sine table read, add and saturate) lie between an accepted
// word and m_valid.
// aresetn is synchronous and active low; it clears only the stage valid bits.
// The whole pipe advances on one enable: it holds when the output word is
// valid and not taken, so s_ready follows m_ready in that case.
module sinusoidal_position_encoder_top (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [spe_pkg::POS_W-1:0]        s_position,
    input  logic [spe_pkg::DIM_W-1:0]        s_dimension,
    input  logic signed [spe_pkg::VAL_W-1:0] s_embedding_value,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic signed [spe_pkg::VAL_W-1:0] m_encoded_value,
    output logic                             m_saturated
);
    import spe_pkg::*;

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'((1 << (VAL_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(1 << (VAL_W - 1));

    logic                    en;
    logic                    v1;
    logic                    v2;
    logic                    v3;
    logic                    v4;
    logic [FREQ_W-1:0]       freq;
    freq_word_t              w1;
    phase_word_t             w2;
    idx_word_t               w3;
    mag_word_t               w4;

    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum;
    logic                    out_valid_reg;
    logic signed [VAL_W-1:0] out_value_reg;
    logic signed [VAL_W-1:0] out_value_next;
    logic                    out_sat_reg;
    logic                    out_sat_next;

    // advance everything unless the output word is stuck
    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    spe_freq_stage u_freq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .en              (en),
        .valid_in        (s_valid),
        .position        (s_position),
        .dimension       (s_dimension),
        .embedding_value (s_embedding_value),
        .valid_reg       (v1),
        .freq_reg        (freq),
        .word_reg        (w1)
    );

    spe_phase_stage u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v1),
        .freq      (freq),
        .word_in   (w1),
        .valid_reg (v2),
        .word_reg  (w2)
    );

    spe_quad_stage u_quad (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v2),
        .word_in   (w2),
        .valid_reg (v3),
        .word_reg  (w3)
    );

    spe_sine_stage u_sine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .valid_in  (v3),
        .word_in   (w3),
        .valid_reg (v4),
        .word_reg  (w4)
    );

    // positional term: signed sine magnitude, zero past the model width
    always_comb begin
        if (!w4.in_range) begin
            term = '0;
        end else if (w4.neg) begin
            term = -SUM_W'(w4.mag);
        end else begin
            term = SUM_W'(w4.mag);
        end
    end

    assign sum = SUM_W'(w4.emb) + term;

    always_comb begin
        if (sum > SUM_MAX) begin
            out_value_next = SUM_MAX[VAL_W-1:0];
            out_sat_next   = 1'b1;
        end else if (sum < SUM_MIN) begin
            out_value_next = SUM_MIN[VAL_W-1:0];
            out_sat_next   = 1'b1;
        end else begin
            out_value_next = sum[VAL_W-1:0];
            out_sat_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v4;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_value_reg <= out_value_next;
            out_sat_reg   <= out_sat_next;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_encoded_value = out_value_reg;
    assign m_saturated     = out_sat_reg;

endmodule

// ===== design/spe_freq_stage.sv =====
// Stage 1: position clamp, range check and registered frequency table read.
module spe_freq_stage (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             en,
    input  logic                             valid_in,
    input  logic [spe_pkg::POS_W-1:0]        position,
    input  logic [spe_pkg::DIM_W-1:0]        dimension,
    input  logic signed [spe_pkg::VAL_W-1:0] embedding_value,
    output logic                             valid_reg,
    output logic [spe_pkg::FREQ_W-1:0]       freq_reg,
    output spe_pkg::freq_word_t              word_reg
);
    import spe_pkg::*;

    freq_word_t       word_next;
    logic [K_W-1:0]   k;

    assign k = dimension[DIM_W-1:1];

    always_comb begin
        word_next.in_range = (32'(dimension) < MODEL_WIDTH);
        word_next.odd      = dimension[0];
        word_next.emb      = embedding_value;
        if (32'(position) >= MAX_POSITION) begin
            word_next.pos = POS_W'(MAX_POSITION - 1);
        end else begin
            word_next.pos = position;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            freq_reg <= FREQ_TAB[k];
            word_reg <= word_next;
        end
    end

endmodule

// ===== design/spe_phase_stage.sv =====
// Stage 2: phase in turns, position times frequency modulo one turn.
module spe_phase_stage (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic [spe_pkg::FREQ_W-1:0] freq,
    input  spe_pkg::freq_word_t        word_in,
    output logic                       valid_reg,
    output spe_pkg::phase_word_t       word_reg
);
    import spe_pkg::*;

    logic [POS_W+FREQ_W-1:0] prod;
    phase_word_t             word_next;

    assign prod = (POS_W+FREQ_W)'(word_in.pos) * (POS_W+FREQ_W)'(freq);

    always_comb begin
        word_next.in_range = word_in.in_range;
        word_next.odd      = word_in.odd;
        word_next.phase    = prod[PHASE_W-1:0];
        word_next.emb      = word_in.emb;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== design/spe_quad_stage.sv =====
// Stage 3: cosine offset, quadrant decode and quarter-wave table index.
module spe_quad_stage (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 valid_in,
    input  spe_pkg::phase_word_t word_in,
    output logic                 valid_reg,
    output spe_pkg::idx_word_t   word_reg
);
    import spe_pkg::*;

    localparam int JP_W = 30 + J_W;

    logic [1:0]      quad;
    logic [29:0]     frac;
    logic [JP_W-1:0] jprod;
    logic [J_W-1:0]  j;
    idx_word_t       word_next;

    // cosine is sine a quarter turn ahead
    assign quad  = word_in.phase[PHASE_W-1 -: 2] + {1'b0, word_in.odd};
    assign frac  = word_in.phase[29:0];
    assign jprod = JP_W'(frac) * JP_W'(SINE_TABLE_DEPTH);
    assign j     = jprod[30 +: J_W];

    always_comb begin
        word_next.in_range = word_in.in_range;
        word_next.neg      = quad[1];
        word_next.emb      = word_in.emb;
        if (quad[0]) begin
            word_next.idx = J_W'(SINE_TABLE_DEPTH) - j;
        end else begin
            word_next.idx = j;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

endmodule

// ===== design/spe_sine_stage.sv =====
// Stage 4: registered quarter-wave sine table read.
module spe_sine_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               valid_in,
    input  spe_pkg::idx_word_t word_in,
    output logic               valid_reg,
    output spe_pkg::mag_word_t word_reg
);
    import spe_pkg::*;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg.in_range <= word_in.in_range;
            word_reg.neg      <= word_in.neg;
            word_reg.mag      <= SINE_TAB[word_in.idx];
            word_reg.emb      <= word_in.emb;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Testbench for the sinusoidal position encoder: random and directed words, scoreboard check.
`timescale 1ns / 1ps

// Fixed-point constants of the encoding, Q30 unless noted.
localparam logic [63:0] ONE_Q30       = 64'd1073741824;
localparam logic [63:0] LN_10K_Q30    = 64'd9889527671;
localparam logic [63:0] LN_2_Q30      = 64'd744261118;
localparam logic [63:0] INV_2PI_Q32   = 64'd683565276;
localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;

typedef struct {
    logic signed [spe_pkg::VAL_W-1:0] value;
    logic                             sat;
} encoded_word_t;

class encoder_scoreboard;
    bit [31:0] turns_per_pos [spe_pkg::PAIRS];
    bit [11:0] quarter_sine [spe_pkg::SINE_TABLE_DEPTH + 1];
    encoded_word_t expected_words[$];
    int faults;

    function new();
        for (int k = 0; k < spe_pkg::PAIRS; k++) begin
            turns_per_pos[k] = turns_for_pair(k);
        end
        for (int j = 0; j <= spe_pkg::SINE_TABLE_DEPTH; j++) begin
            quarter_sine[j] = sine_at(j);
        end
        faults = 0;
    endfunction

    // exp(-2k ln(10000)/d) / (2 pi) as Q0.32 turns; exp split as 2^-n * exp(-r)
    function bit [31:0] turns_for_pair(int k);
        bit [63:0] x;
        bit [63:0] n;
        bit [63:0] r;
        bit [63:0] term;
        bit [63:0] prod;
        longint    acc;
        int        shift;
        x = (64'd2 * 64'(k) * LN_10K_Q30 + 64'(spe_pkg::MODEL_WIDTH / 2))
            / 64'(spe_pkg::MODEL_WIDTH);
        n = x / LN_2_Q30;
        r = x - n * LN_2_Q30;
        term = ONE_Q30;
        acc = longint'(ONE_Q30);
        for (int i = 1; i <= 12; i++) begin
            term = ((term * r) >> 30) / 64'(i);
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (n > 64'd30) begin
            n = 64'd30;
        end
        shift = 30 + int'(n);
        prod = acc;
        prod = prod * INV_2PI_Q32;
        prod = (prod + (64'd1 << (shift - 1))) >> shift;
        if (prod > 64'hFFFF_FFFF) begin
            prod = 64'hFFFF_FFFF;
        end
        return prod[31:0];
    endfunction

    // round(2048 * sin(pi/2 * j / depth)), odd Taylor series
    function bit [11:0] sine_at(int j);
        bit [63:0] a;
        bit [63:0] a2;
        bit [63:0] term;
        bit [63:0] v;
        longint    acc;
        a = HALF_PI_Q30 * 64'(j) / 64'(spe_pkg::SINE_TABLE_DEPTH);
        a2 = (a * a) >> 30;
        term = a;
        acc = longint'(a);
        for (int i = 1; i <= 8; i++) begin
            term = ((term * a2) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = acc;
        v = (v * 64'd2048 + (64'd1 << 29)) >> 30;
        if (v > 64'd2048) begin
            v = 64'd2048;
        end
        return v[11:0];
    endfunction

    // embedding plus sin/cos term, saturated
    function encoded_word_t encode(bit [spe_pkg::POS_W-1:0] pos, bit [spe_pkg::DIM_W-1:0] dim,
                                   logic signed [spe_pkg::VAL_W-1:0] emb);
        encoded_word_t w;
        int unsigned   p;
        int            k;
        bit [31:0]     phase;
        int            j;
        int            term;
        int            total;
        p = 32'(pos);
        if (p >= spe_pkg::MAX_POSITION) begin
            p = spe_pkg::MAX_POSITION - 1;
        end
        term = 0;
        if (32'(dim) < spe_pkg::MODEL_WIDTH) begin
            k = int'(dim[spe_pkg::DIM_W-1:1]);
            if (k >= spe_pkg::PAIRS) begin
                k = spe_pkg::PAIRS - 1;
            end
            phase = 32'(64'(p) * 64'(turns_per_pos[k]));
            if (dim[0]) begin
                phase = phase + 32'h4000_0000;  // cosine: quarter turn ahead
            end
            j = int'((64'(phase[29:0]) * 64'(spe_pkg::SINE_TABLE_DEPTH)) >> 30);
            if (j > spe_pkg::SINE_TABLE_DEPTH) begin
                j = spe_pkg::SINE_TABLE_DEPTH;
            end
            if (phase[30]) begin
                term = int'(quarter_sine[spe_pkg::SINE_TABLE_DEPTH - j]);
            end else begin
                term = int'(quarter_sine[j]);
            end
            if (phase[31]) begin
                term = -term;
            end
        end
        total = int'(emb) + term;
        w.sat = 1'b0;
        if (total > 32767) begin
            total = 32767;
            w.sat = 1'b1;
        end else if (total < -32768) begin
            total = -32768;
            w.sat = 1'b1;
        end
        w.value = 16'(total);
        return w;
    endfunction

    function void note_input(bit [spe_pkg::POS_W-1:0] pos, bit [spe_pkg::DIM_W-1:0] dim,
                             logic signed [spe_pkg::VAL_W-1:0] emb);
        expected_words.push_back(encode(pos, dim, emb));
    endfunction

    function void check_result(logic signed [spe_pkg::VAL_W-1:0] got_value, logic got_sat);
        encoded_word_t want;
        if (expected_words.size() == 0) begin
            faults++;
            if (faults <= 10) begin
                $display("unexpected word: value %0d sat %0b", got_value, got_sat);
            end
            return;
        end
        want = expected_words.pop_front();
        if (got_value !== want.value || got_sat !== want.sat) begin
            faults++;
            if (faults <= 10) begin
                $display("mismatch: value exp %0d got %0d, sat exp %0b got %0b",
                         want.value, got_value, want.sat, got_sat);
            end
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction
endclass

module tb;
    localparam int QUIET_LIMIT = 1000;  // cycles without any handshake before giving up
    localparam int LONG_HOLD   = 80;    // receiver hold-off, well past the pipe depth
    localparam int N_WORDS     = 400;
    localparam int CALM_TAIL   = 60;    // last words run with no idling on either side
    localparam int SETTLE      = 12;    // pipe is five deep; allow margin for strays

    logic                             aclk;
    logic                             aresetn;
    logic                             s_valid;
    logic                             s_ready;
    logic [spe_pkg::POS_W-1:0]        s_position;
    logic [spe_pkg::DIM_W-1:0]        s_dimension;
    logic signed [spe_pkg::VAL_W-1:0] s_embedding_value;
    logic                             m_valid;
    logic                             m_ready;
    logic signed [spe_pkg::VAL_W-1:0] m_encoded_value;
    logic                             m_saturated;

    encoder_scoreboard sb = new();

    bit calm = 1'b0;      // set for the tail: no idling anywhere
    bit hold_req = 1'b0;  // main asks the receiver for one long hold-off
    int sent = 0;

    sinusoidal_position_encoder_top uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_position        (s_position),
        .s_dimension       (s_dimension),
        .s_embedding_value (s_embedding_value),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_encoded_value   (m_encoded_value),
        .m_saturated       (m_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Present one word at the falling edge and hold it until the block takes it.
    // Acceptance is judged from values sampled at the rising edge.
    task automatic send_word(input logic [spe_pkg::POS_W-1:0] pos,
                             input logic [spe_pkg::DIM_W-1:0] dim,
                             input logic signed [spe_pkg::VAL_W-1:0] emb);
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_position        <= pos;
        s_dimension       <= dim;
        s_embedding_value <= emb;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(pos, dim, emb);
        sent++;
    endtask

    // Sender gap: valid low, payload scrambled so a stale word would show up.
    task automatic sender_idle(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid           <= 1'b0;
            s_position        <= 12'($urandom);
            s_dimension       <= 9'($urandom);
            s_embedding_value <= 16'($urandom);
        end
    endtask

    task automatic maybe_gap();
        if (!calm && $urandom_range(0, 4) == 0) begin
            sender_idle($urandom_range(1, 19));
        end
    endtask

    // Random word, weighted toward the rails so clipping happens often,
    // and toward small positions where the low pairs still turn slowly.
    task automatic send_random_word();
        logic [spe_pkg::POS_W-1:0]        pos;
        logic [spe_pkg::DIM_W-1:0]        dim;
        logic signed [spe_pkg::VAL_W-1:0] emb;
        pos = 12'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 4095)
                                              : $urandom_range(0, 63));
        dim = 9'($urandom_range(0, 511));
        case ($urandom_range(0, 3))
            0, 1: emb = 16'($urandom);
            2: emb = 16'(32767 - int'($urandom_range(0, 2500)));
            default: emb = 16'(-32768 + int'($urandom_range(0, 2500)));
        endcase
        send_word(pos, dim, emb);
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // Result side: runs of ready, random stall bursts, and one long hold-off
    // on request. Each pass assigns m_ready once at its first falling edge.
    initial begin
        int n;
        m_ready = 1'b0;
        forever begin
            if (hold_req) begin
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 19);
                @(negedge aclk);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                n = $urandom_range(1, 30);
                @(negedge aclk);
                m_ready <= 1'b1;
                repeat (n - 1) @(negedge aclk);
            end
        end
    end

    // Output monitor: m_valid and data are registers, so the values seen
    // right after the rising edge are the ones that were handed over.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_encoded_value, m_saturated);
        end
    end

    // Watchdog: a stuck handshake on either side ends the run.
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= QUIET_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    initial begin
        s_valid           = 1'b0;
        s_position        = '0;
        s_dimension       = '0;
        s_embedding_value = '0;
        aresetn           = 1'b0;
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed words. Position and dimension fields are 12 and 9 bits, so
        // with 4096 positions and width 512 neither can reach its clamp here.
        send_word(12'd0,    9'd0,   16'sd0);        // sin(0) = 0
        send_word(12'd0,    9'd1,   16'sd0);        // cos(0) = full scale
        send_word(12'd4095, 9'd510, 16'sd0);        // last sine column, last row
        maybe_gap();
        send_word(12'd4095, 9'd511, 16'sd0);        // last cosine column
        send_word(12'd0,    9'd1,   16'sh7FFF);     // positive clip
        send_word(12'd0,    9'd0,   16'sh7FFF);     // at the rail, no clip
        send_word(12'd4,    9'd0,   -16'sd32768);   // third quadrant: negative clip
        maybe_gap();
        send_word(12'd0,    9'd1,   -16'sd32768);   // negative rail pulled up
        send_word(12'd2,    9'd0,   16'sd100);      // second quadrant
        send_word(12'd3,    9'd1,   16'sd0);        // cosine near half turn
        send_word(12'd5,    9'd0,   -16'sd1);       // fourth quadrant
        send_word(12'd4095, 9'd0,   16'sh7FFF);
        maybe_gap();
        send_word(12'd4095, 9'd1,   -16'sd32768);
        send_word(12'd2048, 9'd255, 16'sh1234);
        send_word(12'd100,  9'd300, 16'sd12345);
        send_word(12'd3000, 9'd77,  -16'sd20000);
        send_word(12'h555,  9'h0AA, 16'sh5555);     // alternating bit patterns
        send_word(12'hAAA,  9'h155, -16'sh5556);
        send_word(12'd1,    9'd511, 16'sd0);
        send_word(12'd1,    9'd2,   16'sd0);

        // Random body, with one long receiver hold-off while words keep coming
        // (pipe fills and s_ready drops) and one sender pause that drains.
        while (sent < N_WORDS - CALM_TAIL) begin
            if (sent == 120) begin
                hold_req = 1'b1;
                do send_random_word(); while (hold_req);
            end else if (sent == 240) begin
                sender_idle(1);
                wait_for_results();
            end
            send_random_word();
            maybe_gap();
        end

        // Back-to-back tail at full rate.
        calm = 1'b1;
        repeat (CALM_TAIL) send_random_word();
        sender_idle(1);

        wait_for_results();
        repeat (SETTLE) @(posedge aclk);
        if (sb.faults == 0 && sb.pending() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
design/spe_pkg.sv
design/spe_freq_stage.sv
design/spe_phase_stage.sv
design/spe_quad_stage.sv
design/spe_sine_stage.sv
design/sinusoidal_position_encoder_top.sv
tb/tb.sv
